// ----- design/fdsc16_pkg.sv -----
// ----------------------------------------------------------------------------
// fdsc16_pkg
// Shared types and constants for the frame deframer with 16-bit sum check.
// ----------------------------------------------------------------------------
package fdsc16_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [1:0] CFG_MIN_FRAME     = 2'd2;

    // Configuration reset values
    localparam logic [7:0] HEADER_FIRST_RST  = 8'd170;
    localparam logic [7:0] HEADER_SECOND_RST = 8'd85;
    localparam logic [7:0] MIN_FRAME_RST     = 8'd6;

    // Frame layout positions
    localparam logic [7:0] POS_HEADER_FIRST  = 8'd0;
    localparam logic [7:0] POS_HEADER_SECOND = 8'd1;
    localparam logic [7:0] POS_MESSAGE_ID    = 8'd2;
    localparam logic [7:0] POS_LENGTH        = 8'd3;
    localparam logic [7:0] POS_PAYLOAD       = 8'd4;
    localparam logic [7:0] COUNT_MAX         = 8'd255;
    localparam logic [7:0] MIN_HEADER_BYTES  = 8'd2;

    // Verdict codes
    localparam logic [2:0] VD_OK        = 3'd0;
    localparam logic [2:0] VD_SHORT     = 3'd1;
    localparam logic [2:0] VD_LEN_EXCEED = 3'd2;
    localparam logic [2:0] VD_TRUNCATED = 3'd3;
    localparam logic [2:0] VD_HEADER    = 3'd4;
    localparam logic [2:0] VD_CHECKSUM  = 3'd5;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] min_frame_bytes;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic       is_verdict;
        logic [7:0] message_id;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] payload_length;
        logic [2:0] verdict;
    } res_t;

endpackage

// ----- design/fdsc16_core.sv -----
// ----------------------------------------------------------------------------
// fdsc16_core
// Frame state and per-byte parse: header match, id and length capture,
// running sum, received checksum and end-of-buffer verdict.
// ----------------------------------------------------------------------------
module fdsc16_core
    import fdsc16_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  logic       end_of_buffer,
    input  cfg_t       cfg,
    output res_t       res
);

    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  frame_id_reg, frame_id_next;
    logic [7:0]  length_reg, length_next;
    logic        header_match_reg, header_match_next;
    logic [15:0] running_sum_reg, running_sum_next;
    logic [15:0] received_sum_reg, received_sum_next;
    logic        sum_complete_reg, sum_complete_next;

    logic [7:0]  pos;
    logic [7:0]  pay_off;
    logic [8:0]  len_plus1;
    logic        count_ok;
    logic        past_head;
    logic        in_payload;
    logic        cks_lo;
    logic        cks_hi;
    logic [2:0]  verdict;

    assign pos       = byte_count_reg;
    assign count_ok  = (pos != COUNT_MAX);
    assign pay_off   = pos - POS_PAYLOAD;
    assign len_plus1 = {1'b0, length_reg} + 9'd1;
    assign past_head = (pos >= POS_PAYLOAD);
    assign in_payload = past_head && (pay_off < length_reg);
    assign cks_lo    = past_head && (pay_off == length_reg);
    assign cks_hi    = past_head && ({1'b0, pay_off} == len_plus1);

    // Update frame state for one byte
    always_comb begin
        byte_count_next   = byte_count_reg;
        frame_id_next     = frame_id_reg;
        length_next       = length_reg;
        header_match_next = header_match_reg;
        running_sum_next  = running_sum_reg;
        received_sum_next = received_sum_reg;
        sum_complete_next = sum_complete_reg;
        if (count_ok) begin
            byte_count_next = pos + 8'd1;
            case (pos)
                POS_HEADER_FIRST:  header_match_next = (rx_byte == cfg.header_first);
                POS_HEADER_SECOND: header_match_next = header_match_reg &&
                                                       (rx_byte == cfg.header_second);
                POS_MESSAGE_ID:    frame_id_next = rx_byte;
                POS_LENGTH:        length_next = rx_byte;
                default:           ;
            endcase
            if (!past_head || in_payload) begin
                running_sum_next = running_sum_reg + {8'd0, rx_byte};
            end
            if (cks_lo) begin
                received_sum_next = {received_sum_reg[15:8], rx_byte};
            end else if (cks_hi) begin
                received_sum_next = {rx_byte, received_sum_reg[7:0]};
                sum_complete_next = 1'b1;
            end
        end
    end

    // Verdict on the state as left by this byte
    always_comb begin
        if (byte_count_next < cfg.min_frame_bytes) begin
            verdict = VD_SHORT;
        end else if (byte_count_next < length_next) begin
            verdict = VD_LEN_EXCEED;
        end else if (byte_count_next < MIN_HEADER_BYTES || !header_match_next) begin
            verdict = VD_HEADER;
        end else if (!sum_complete_next) begin
            verdict = VD_TRUNCATED;
        end else if (running_sum_next != received_sum_next) begin
            verdict = VD_CHECKSUM;
        end else begin
            verdict = VD_OK;
        end
    end

    // Form the result: verdict wins over a payload byte
    always_comb begin
        res = '0;
        if (end_of_buffer) begin
            res.valid          = 1'b1;
            res.is_verdict     = 1'b1;
            res.message_id     = frame_id_next;
            res.payload_length = length_next;
            res.verdict        = verdict;
        end else if (count_ok && in_payload && header_match_reg) begin
            res.valid          = 1'b1;
            res.message_id     = frame_id_reg;
            res.payload_byte   = rx_byte;
            res.payload_index  = pay_off;
            res.payload_length = length_reg;
        end
    end

    // Hold frame state; clear at the end of each buffer
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && end_of_buffer)) begin
            byte_count_reg   <= '0;
            frame_id_reg     <= '0;
            length_reg       <= '0;
            header_match_reg <= 1'b0;
            running_sum_reg  <= '0;
            received_sum_reg <= '0;
            sum_complete_reg <= 1'b0;
        end else if (step) begin
            byte_count_reg   <= byte_count_next;
            frame_id_reg     <= frame_id_next;
            length_reg       <= length_next;
            header_match_reg <= header_match_next;
            running_sum_reg  <= running_sum_next;
            received_sum_reg <= received_sum_next;
            sum_complete_reg <= sum_complete_next;
        end
    end

endmodule

// ----- design/frame_deframer_sum16_check.sv -----
// ----------------------------------------------------------------------------
// frame_deframer_sum16_check
// Byte-serial frame parser with a little-endian 16-bit additive checksum.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one buffer byte per request, s_end_of_buffer on the last byte.
//   m_ channel: a payload result for each payload byte of a frame whose two
//   header bytes matched; the last buffer byte gives one verdict result instead.
//   The receiver discards the payload unless the verdict is ok.
//   cfg_ channel: writes header_first (0), header_second (1) and
//   min_frame_bytes (2); other indexes are ignored. Write only while idle.
// Timing:
//   A byte is held in the input register and its result is captured in
//   the output register that drives m_. One byte is taken every cycle while
//   m_ is not stalled; the rate is set by the combinational parse between
//   the two registers. A byte that gives no result leaves nothing behind.
// Reset and stall:
//   aresetn clears the frame state and both registers and reloads the
//   configuration defaults. While m_ready is low with a result waiting, the
//   pipeline holds and s_ready drops once the input register is full.
// ----------------------------------------------------------------------------
module frame_deframer_sum16_check
    import fdsc16_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_end_of_buffer,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_is_verdict,
    output logic [7:0] m_message_id,
    output logic [7:0] m_payload_byte,
    output logic [7:0] m_payload_index,
    output logic [7:0] m_payload_length,
    output logic [2:0] m_verdict,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    res_t       out_reg;
    res_t       res;
    logic       advance;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_first    <= HEADER_FIRST_RST;
            cfg_reg.header_second   <= HEADER_SECOND_RST;
            cfg_reg.min_frame_bytes <= MIN_FRAME_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_HEADER_FIRST:  cfg_reg.header_first    <= cfg_data;
                CFG_HEADER_SECOND: cfg_reg.header_second   <= cfg_data;
                CFG_MIN_FRAME:     cfg_reg.min_frame_bytes <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Advance when the output register is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
            in_last_reg <= s_end_of_buffer;
        end
    end

    fdsc16_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .rx_byte       (in_byte_reg),
        .end_of_buffer (in_last_reg),
        .cfg           (cfg_reg),
        .res           (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res.valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            out_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_is_verdict     = out_reg.is_verdict;
    assign m_message_id     = out_reg.message_id;
    assign m_payload_byte   = out_reg.payload_byte;
    assign m_payload_index  = out_reg.payload_index;
    assign m_payload_length = out_reg.payload_length;
    assign m_verdict        = out_reg.verdict;

`ifndef SYNTHESIS
    a_payload_no_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_verdict) |-> (m_verdict == VD_OK))
        else $error("payload result carries a verdict code");

    a_payload_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_verdict) |-> (m_payload_index < m_payload_length))
        else $error("payload index beyond declared length");

    a_verdict_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_verdict) |-> (m_payload_byte == 8'd0 && m_payload_index == 8'd0))
        else $error("verdict result carries payload data");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |=> in_valid_reg)
        else $error("input request lost during output stall");
`endif

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte-serial frame deframer with 16-bit sum check.
// Buffers are streamed byte by byte through the s_ channel. A cycle-free model
// of the parser predicts every payload and verdict result, and each m_ result
// is checked field by field against it. The run starts with directed corner
// frames, then moves to random frames under several idle and stall mixes and
// ends with long frames that reach the byte count ceiling.
// ----------------------------------------------------------------------------
module tb;
    import fdsc16_pkg::*;

    localparam int         CLK_HALF      = 4;
    localparam int         RESET_CYCLES  = 12;
    localparam int         CYCLE_LIMIT   = 600000;
    localparam int         SETTLE_CYCLES = 6;
    localparam int         PHASE_BYTES   = 300;
    localparam int         MAX_GAP       = 40;
    localparam logic [1:0] CFG_UNUSED    = 2'd3;

    typedef struct packed {
        logic       is_verdict;
        logic [7:0] message_id;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] payload_length;
        logic [2:0] verdict;
    } deframe_out_t;

    typedef enum int {
        FR_GOOD,
        FR_BAD_HEADER,
        FR_BAD_SUM,
        FR_CUT_SHORT,
        FR_NOISE
    } frame_kind_e;

    logic       aclk;
    logic       aresetn         = 1'b0;
    logic       s_valid         = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte       = 8'd0;
    logic       s_end_of_buffer = 1'b0;
    logic       m_valid;
    logic       m_ready         = 1'b0;
    logic       m_is_verdict;
    logic [7:0] m_message_id;
    logic [7:0] m_payload_byte;
    logic [7:0] m_payload_index;
    logic [7:0] m_payload_length;
    logic [2:0] m_verdict;
    logic       cfg_valid       = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index       = 2'd0;
    logic [7:0] cfg_data        = 8'd0;

    // Parser model: configuration and frame state
    cfg_t        cfg_model;
    logic [7:0]  seen_count;
    logic [7:0]  frame_tag;
    logic [7:0]  decl_len;
    logic        hdr_ok;
    logic [15:0] run_sum;
    logic [15:0] rx_sum;
    logic        sum_done;

    deframe_out_t due_results[$];
    deframe_out_t head_result;
    logic [7:0]   buf_bytes[$];

    int send_idle_pct = 0;
    int rx_stall_pct  = 0;
    int fail_count    = 0;
    int cycle_count   = 0;
    int bytes_sent    = 0;
    int bytes_parsed  = 0;
    int writes_done   = 0;
    int payload_seen  = 0;
    int verdict_tally[6];

    frame_deframer_sum16_check dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_end_of_buffer (s_end_of_buffer),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_verdict    (m_is_verdict),
        .m_message_id    (m_message_id),
        .m_payload_byte  (m_payload_byte),
        .m_payload_index (m_payload_index),
        .m_payload_length(m_payload_length),
        .m_verdict       (m_verdict),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("cycle limit reached with %0d results outstanding", due_results.size());
            $display("frame_deframer_sum16_check verification failed");
            $finish;
        end
    end

    // Randomise receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    function automatic void clear_frame_state();
        seen_count = 8'd0;
        frame_tag  = 8'd0;
        decl_len   = 8'd0;
        hdr_ok     = 1'b0;
        run_sum    = 16'd0;
        rx_sum     = 16'd0;
        sum_done   = 1'b0;
    endfunction

    // Advance the parser model by one accepted byte and queue what it yields
    function automatic void deframe_byte(input logic [7:0] b, input logic last);
        int           pos;
        int           len;
        int           pay_pos;
        logic         payload_out;
        logic [2:0]   vd;
        deframe_out_t r;
        payload_out = 1'b0;
        r = '0;
        if (seen_count != COUNT_MAX) begin
            pos     = int'(seen_count);
            len     = int'(decl_len);
            pay_pos = pos - int'(POS_PAYLOAD);
            seen_count = seen_count + 8'd1;
            bytes_parsed++;
            if (pos == int'(POS_HEADER_FIRST))
                hdr_ok = (b == cfg_model.header_first);
            else if (pos == int'(POS_HEADER_SECOND))
                hdr_ok = hdr_ok && (b == cfg_model.header_second);
            else if (pos == int'(POS_MESSAGE_ID))
                frame_tag = b;
            else if (pos == int'(POS_LENGTH))
                decl_len = b;
            // header, id, length and payload feed the sum
            if (pay_pos < 0 || pay_pos < len)
                run_sum = run_sum + {8'd0, b};
            if (pay_pos >= 0 && pay_pos < len) begin
                if (hdr_ok) begin
                    payload_out = 1'b1;
                    r = '{1'b0, frame_tag, b, 8'(pay_pos), 8'(len), VD_OK};
                end
            end else if (pay_pos >= 0 && pay_pos == len) begin
                rx_sum[7:0] = b;
            end else if (pay_pos >= 0 && pay_pos == len + 1) begin
                rx_sum[15:8] = b;
                sum_done     = 1'b1;
            end
        end
        if (last) begin
            if (seen_count < cfg_model.min_frame_bytes)
                vd = VD_SHORT;
            else if (seen_count < decl_len)
                vd = VD_LEN_EXCEED;
            else if (seen_count < MIN_HEADER_BYTES || !hdr_ok)
                vd = VD_HEADER;
            else if (!sum_done)
                vd = VD_TRUNCATED;
            else if (run_sum != rx_sum)
                vd = VD_CHECKSUM;
            else
                vd = VD_OK;
            // the verdict displaces any payload result of the last byte
            due_results.push_back('{1'b1, frame_tag, 8'd0, 8'd0, decl_len, vd});
            clear_frame_state();
        end else if (payload_out) begin
            due_results.push_back(r);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Check each result against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result: is_verdict %0d id %0d byte %0d index %0d verdict %0d",
                       m_is_verdict, m_message_id, m_payload_byte, m_payload_index, m_verdict);
                fail_count++;
            end else begin
                head_result = due_results.pop_front();
                check_field("is_verdict", head_result.is_verdict, m_is_verdict);
                check_field("message_id", head_result.message_id, m_message_id);
                check_field("payload_byte", head_result.payload_byte, m_payload_byte);
                check_field("payload_index", head_result.payload_index, m_payload_index);
                check_field("payload_length", head_result.payload_length, m_payload_length);
                check_field("verdict", head_result.verdict, m_verdict);
                if (!head_result.is_verdict)
                    payload_seen++;
                else if (head_result.verdict <= VD_CHECKSUM)
                    verdict_tally[head_result.verdict]++;
            end
        end
    end

    // Send one byte request; entered and left at a falling edge, valid left high
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_rx_byte       <= b;
        s_end_of_buffer <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        deframe_byte(b, last);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Drop valid and hold until every predicted result has come out
    task automatic go_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            CFG_HEADER_FIRST:  cfg_model.header_first    = val;
            CFG_HEADER_SECOND: cfg_model.header_second   = val;
            CFG_MIN_FRAME:     cfg_model.min_frame_bytes = val;
            default: ;
        endcase
        writes_done++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [7:0] hf, input logic [7:0] hs,
                              input logic [7:0] min_bytes);
        go_quiet();
        write_reg(CFG_HEADER_FIRST, hf);
        write_reg(CFG_HEADER_SECOND, hs);
        write_reg(CFG_MIN_FRAME, min_bytes);
    endtask

    // Stream buf_bytes as one buffer, sometimes pausing until drained
    task automatic send_buffer();
        foreach (buf_bytes[i])
            send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
        if ($urandom_range(0, 11) == 0)
            go_quiet();
    endtask

    // Assemble a frame of the given kind for the current headers
    task automatic build_frame(input frame_kind_e kind, input int len);
        logic [15:0] csum;
        int          idx;
        buf_bytes.delete();
        if (kind == FR_NOISE) begin
            repeat (len) buf_bytes.push_back(8'($urandom));
            return;
        end
        buf_bytes.push_back(cfg_model.header_first);
        buf_bytes.push_back(cfg_model.header_second);
        buf_bytes.push_back(8'($urandom));
        buf_bytes.push_back(8'(len));
        repeat (len) buf_bytes.push_back(8'($urandom));
        csum = 16'd0;
        foreach (buf_bytes[i])
            csum = csum + {8'd0, buf_bytes[i]};
        buf_bytes.push_back(csum[7:0]);
        buf_bytes.push_back(csum[15:8]);
        case (kind)
            FR_BAD_HEADER: begin
                idx = $urandom_range(0, 1);
                buf_bytes[idx] = buf_bytes[idx] ^ 8'($urandom_range(1, 255));
            end
            FR_BAD_SUM: begin
                idx = buf_bytes.size() - 1 - $urandom_range(0, 1);
                buf_bytes[idx] = buf_bytes[idx] ^ 8'($urandom_range(1, 255));
            end
            FR_CUT_SHORT: begin
                repeat ($urandom_range(1, buf_bytes.size() - 1))
                    void'(buf_bytes.pop_back());
            end
            default: ;
        endcase
        // trailing bytes past the checksum are ignored by the parser
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) buf_bytes.push_back(8'($urandom));
    endtask

    // Reset defaults: good frame with trailer, short buffer, oversized length
    task automatic test_reset_defaults();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        buf_bytes = '{HEADER_FIRST_RST, HEADER_SECOND_RST, 8'hFF, 8'h00, 8'hFE, 8'h01, 8'h00};
        send_buffer();
        buf_bytes = '{8'h00};
        send_buffer();
        buf_bytes = '{HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h00, 8'hFF, 8'h00, 8'hFF};
        send_buffer();
    endtask

    // Extreme register values, ignored index, tiny buffers, bad checksum
    task automatic test_corner_config();
        set_config(8'h00, 8'hFF, 8'h00);
        write_reg(CFG_UNUSED, 8'h5A);
        // fewer than two bytes: header verdict even though the first byte matches
        buf_bytes = '{8'h00};
        send_buffer();
        // headers only: checksum never arrives
        buf_bytes = '{8'h00, 8'hFF};
        send_buffer();
        buf_bytes = '{8'h00, 8'hFF, 8'h7E, 8'h01, 8'h80, 8'h01, 8'h02};
        send_buffer();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [7:0] hf, input logic [7:0] hs,
                                       input logic [7:0] min_bytes);
        int          start;
        int          pick;
        int          len;
        frame_kind_e kind;
        set_config(hf, hs, min_bytes);
        send_idle_pct = idle_pct;
        rx_stall_pct  = stall_pct;
        start = bytes_parsed;
        while (bytes_parsed - start < PHASE_BYTES) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
            if (pick < 55)
                kind = FR_GOOD;
            else if (pick < 65)
                kind = FR_BAD_HEADER;
            else if (pick < 75)
                kind = FR_BAD_SUM;
            else if (pick < 88)
                kind = FR_CUT_SHORT;
            else begin
                kind = FR_NOISE;
                len  = $urandom_range(1, 12);
            end
            build_frame(kind, len);
            send_buffer();
        end
    endtask

    // Longest lengths: oversized declared length and byte count saturation
    task automatic test_long_frames();
        set_config(8'($urandom), 8'($urandom), 8'h00);
        send_idle_pct = 34;
        rx_stall_pct  = 34;
        build_frame(FR_GOOD, 255);
        while (buf_bytes.size() > 120)
            void'(buf_bytes.pop_back());
        send_buffer();
        set_config(cfg_model.header_first, cfg_model.header_second, 8'hFF);
        // a length of 250 cannot complete before the count saturates
        build_frame(FR_GOOD, 250);
        send_buffer();
        buf_bytes = '{8'h01};
        send_buffer();
    endtask

    initial begin
        cfg_model = '{HEADER_FIRST_RST, HEADER_SECOND_RST, MIN_FRAME_RST};
        clear_frame_state();
        foreach (verdict_tally[i])
            verdict_tally[i] = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_corner_config();
        test_random_traffic(0, 0, 8'h00, 8'hFF, 8'd0);
        test_random_traffic(83, 0, 8'hFF, 8'h00, MIN_FRAME_RST);
        test_random_traffic(0, 83, 8'($urandom), 8'($urandom), 8'($urandom_range(2, 10)));
        test_random_traffic(34, 34, 8'h3C, 8'h3C, 8'd1);
        test_long_frames();
        go_quiet();

        $display("Streamed %0d bytes (%0d parsed) with %0d register writes; %0d payload results.",
                 bytes_sent, bytes_parsed, writes_done, payload_seen);
        $display("Verdicts: ok %0d short %0d exceed %0d truncated %0d header %0d checksum %0d.",
                 verdict_tally[VD_OK], verdict_tally[VD_SHORT], verdict_tally[VD_LEN_EXCEED],
                 verdict_tally[VD_TRUNCATED], verdict_tally[VD_HEADER],
                 verdict_tally[VD_CHECKSUM]);
        if (fail_count == 0)
            $display("frame_deframer_sum16_check verification clean");
        else
            $display("frame_deframer_sum16_check verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/fdsc16_pkg.sv
design/fdsc16_core.sv
design/frame_deframer_sum16_check.sv
verif/tb.sv
